// ----- sv/x86_subset_relocating_copier_defines.svh -----
// Assertion macros shared by the relocating copier RTL.
`ifndef X86_SUBSET_RELOCATING_COPIER_DEFINES_SVH
`define X86_SUBSET_RELOCATING_COPIER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property that is switched off while reset is high.
`define XSRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("xsrc assertion failed");
// Checked property that also holds across reset.
`define XSRC_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("xsrc assertion failed");
`else
`define XSRC_ASSERT(lbl, clk, rst, prop)
`define XSRC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ----- sv/xsrc_pkg.sv -----
// Types, constants and decode helpers of the relocating code copier.
package xsrc_pkg;

   localparam int PositionBits = 16;
   localparam int RegIndexBits = 2;
   localparam int OutPosBits   = 16;

   localparam logic [7:0] RexLo      = 8'h40;
   localparam logic [7:0] RexHi      = 8'h4F;
   localparam logic [7:0] OpEsc      = 8'h0F;
   localparam logic [7:0] OpBt       = 8'hBA;
   localparam logic [7:0] OpJb       = 8'h72;
   localparam logic [7:0] OpLea      = 8'h8D;
   localparam logic [7:0] OpIret     = 8'hCF;
   localparam logic [7:0] OpCall     = 8'hE8;
   localparam logic [7:0] OpGrp5     = 8'hFF;
   localparam logic [7:0] OpStackLo  = 8'h50;
   localparam logic [7:0] OpStackHi  = 8'h5F;
   localparam logic [7:0] OpPushf    = 8'h9C;
   localparam logic [7:0] OpXchg     = 8'h87;
   localparam logic [7:0] OpMovStore = 8'h89;
   localparam logic [7:0] OpMovLoad  = 8'h8B;
   localparam logic [7:0] OpMovSeg   = 8'h8E;
   localparam logic [1:0] ModDisp8  = 2'd1;
   localparam logic [1:0] ModDisp32 = 2'd2;
   localparam logic [1:0] ModReg    = 2'd3;
   localparam logic [1:0] ModMem    = 2'd0;
   localparam logic [2:0] RmSib     = 3'd4;
   localparam logic [2:0] RmRip     = 3'd5;

   typedef enum logic [RegIndexBits-1:0] {
      REG_RELOC     = 2'd0,
      REG_CALL_BASE = 2'd1,
      REG_LIMIT     = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_COPY   = 3'd0,
      ST_IRET   = 3'd1,
      ST_ERROR  = 3'd2,
      ST_IGNORE = 3'd3,
      ST_LIMIT  = 3'd4
   } status_type;

   typedef enum logic [7:0] {
      PH_START = 8'b0000_0001,
      PH_OPC   = 8'b0000_0010,
      PH_OPC2  = 8'b0000_0100,
      PH_MODRM = 8'b0000_1000,
      PH_SIB   = 8'b0001_0000,
      PH_DISP  = 8'b0010_0000,
      PH_CALL  = 8'b0100_0000,
      PH_IMM   = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      OP_ESC,
      OP_SINGLE,
      OP_IMM,
      OP_MODRM,
      OP_IRET,
      OP_CALL,
      OP_BAD
   } op_class_type;

   typedef struct packed {
      phase_type               phase;
      logic [PositionBits-1:0] pos;
      logic [2:0]              bytes_left;
      logic                    flag_imm;
      logic                    flag_rip;
      logic                    carry;
      logic [31:0]             call_value;
      logic                    finished;
   } parse_state_type;

   localparam parse_state_type ParseReset = '{
      phase:      PH_START,
      pos:        '0,
      bytes_left: 3'd0,
      flag_imm:   1'b0,
      flag_rip:   1'b0,
      carry:      1'b0,
      call_value: 32'd0,
      finished:   1'b1
   };

   typedef struct packed {
      logic [31:0] reloc_distance;
      logic [31:0] call_offset_base;
      logic [15:0] length_limit;
   } csr_type;

   typedef struct packed {
      logic [7:0]            copied_byte;
      logic [OutPosBits-1:0] byte_position;
      status_type            status;
   } result_type;

   // Classifies a primary opcode byte of the supported subset.
   function automatic op_class_type classify_opcode(input logic [7:0] b);
      op_class_type c;
      unique case (b) inside
         OpEsc:                                   c = OP_ESC;
         [OpStackLo:OpStackHi], OpPushf:          c = OP_SINGLE;
         OpJb:                                    c = OP_IMM;
         OpXchg, OpMovStore, OpMovLoad, OpLea, OpMovSeg, OpGrp5: c = OP_MODRM;
         OpIret:                                  c = OP_IRET;
         OpCall:                                  c = OP_CALL;
         default:                                 c = OP_BAD;
      endcase
      return c;
   endfunction

endpackage

// ----- sv/xsrc_if.sv -----
// Valid/ready channel interfaces for code bytes, results and register writes.
interface xsrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       region_start;
   modport source (output valid, output code_byte, output region_start, input ready);
   modport sink   (input valid, input code_byte, input region_start, output ready);
endinterface

interface xsrc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [7:0]                        copied_byte;
   logic [xsrc_pkg::OutPosBits-1:0]   byte_position;
   logic [2:0]                        status;
   modport source (output valid, output copied_byte, output byte_position,
                   output status, input ready);
   modport sink   (input valid, input copied_byte, input byte_position,
                   input status, output ready);
endinterface

interface xsrc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [xsrc_pkg::RegIndexBits-1:0] reg_index;
   logic [31:0]                       wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- sv/xsrc_step.sv -----
// Per-byte decode step: next parse state and the result beat for one code byte.
module xsrc_step (
   input  xsrc_pkg::parse_state_type cur_state,
   input  xsrc_pkg::csr_type         cfg,
   input  logic [7:0]                code_byte,
   input  logic                      region_start,
   output xsrc_pkg::parse_state_type nxt_state,
   output xsrc_pkg::result_type      result
);

   function automatic xsrc_pkg::parse_state_type clear_parse(
      input xsrc_pkg::parse_state_type v);
      xsrc_pkg::parse_state_type r;
      r            = v;
      r.phase      = xsrc_pkg::PH_START;
      r.bytes_left = 3'd0;
      r.flag_imm   = 1'b0;
      r.flag_rip   = 1'b0;
      r.carry      = 1'b0;
      r.call_value = 32'd0;
      return r;
   endfunction

   // Leaves the ModRM/SIB/displacement fields: an immediate may still follow.
   function automatic xsrc_pkg::parse_state_type after_fields(
      input xsrc_pkg::parse_state_type v);
      xsrc_pkg::parse_state_type r;
      r            = v;
      r.flag_rip   = 1'b0;
      r.carry      = 1'b0;
      r.bytes_left = 3'd0;
      r.phase      = v.flag_imm ? xsrc_pkg::PH_IMM : xsrc_pkg::PH_START;
      return r;
   endfunction

   xsrc_pkg::parse_state_type s;
   xsrc_pkg::op_class_type    opc;
   xsrc_pkg::status_type      status;
   logic [7:0]                outb;
   logic                      no_copy;
   logic                      take_op;
   logic                      is_rex;
   logic                      limit_hit;
   logic [1:0]                modf;
   logic [2:0]                rmf;
   logic [2:0]                cnt;
   logic [1:0]                k;
   logic [8:0]                sum;
   logic [xsrc_pkg::PositionBits-1:0] pos_cur;

   assign opc    = xsrc_pkg::classify_opcode(code_byte);
   assign is_rex = (code_byte >= xsrc_pkg::RexLo) && (code_byte <= xsrc_pkg::RexHi);
   assign modf   = code_byte[7:6];
   assign rmf    = code_byte[2:0];

   always_comb begin
      s = cur_state;
      if (region_start) begin
         s          = clear_parse(s);
         s.pos      = '0;
         s.finished = 1'b0;
      end
      pos_cur   = s.pos;
      limit_hit = (32'(s.pos) >= 32'(cfg.length_limit));
      outb      = code_byte;
      status    = xsrc_pkg::ST_COPY;
      no_copy   = 1'b0;
      take_op   = 1'b0;
      cnt       = 3'd0;
      k         = 2'd0;
      sum       = 9'd0;

      if (s.finished) begin
         no_copy = 1'b1;
         status  = xsrc_pkg::ST_IGNORE;
      end else begin
         unique case (s.phase)
            xsrc_pkg::PH_START: begin
               if (limit_hit) begin
                  s          = clear_parse(s);
                  s.finished = 1'b1;
                  no_copy    = 1'b1;
                  status     = xsrc_pkg::ST_LIMIT;
               end else if (is_rex) begin
                  s.phase = xsrc_pkg::PH_OPC;
               end else begin
                  take_op = 1'b1;
               end
            end
            xsrc_pkg::PH_OPC: take_op = 1'b1;
            xsrc_pkg::PH_OPC2: begin
               if (code_byte == xsrc_pkg::OpBt) begin
                  s.flag_imm = 1'b1;
                  s.flag_rip = 1'b0;
                  s.phase    = xsrc_pkg::PH_MODRM;
               end else begin
                  s          = clear_parse(s);
                  s.finished = 1'b1;
                  status     = xsrc_pkg::ST_ERROR;
               end
            end
            xsrc_pkg::PH_MODRM: begin
               if (modf == xsrc_pkg::ModMem && rmf == xsrc_pkg::RmRip) begin
                  cnt        = 3'd4;
                  s.flag_rip = 1'b1;
                  s.carry    = 1'b0;
               end else if (modf == xsrc_pkg::ModDisp8) begin
                  cnt = 3'd1;
               end else if (modf == xsrc_pkg::ModDisp32) begin
                  cnt = 3'd4;
               end
               s.bytes_left = cnt;
               if (modf != xsrc_pkg::ModReg && rmf == xsrc_pkg::RmSib) begin
                  s.phase = xsrc_pkg::PH_SIB;
               end else if (cnt != 3'd0) begin
                  s.phase = xsrc_pkg::PH_DISP;
               end else begin
                  s = after_fields(s);
               end
            end
            xsrc_pkg::PH_SIB: begin
               if (s.bytes_left != 3'd0) begin
                  s.phase = xsrc_pkg::PH_DISP;
               end else begin
                  s = after_fields(s);
               end
            end
            xsrc_pkg::PH_DISP: begin
               if (s.flag_rip) begin
                  // Byte lane of the distance: 4 left is lane 0, 1 left is lane 3.
                  k       = 2'(3'd4 - s.bytes_left);
                  sum     = {1'b0, code_byte}
                            + {1'b0, cfg.reloc_distance[{k, 3'b000} +: 8]}
                            + 9'(s.carry);
                  outb    = sum[7:0];
                  s.carry = sum[8];
               end
               if (s.bytes_left != 3'd0) begin
                  s.bytes_left = s.bytes_left - 3'd1;
               end
               if (s.bytes_left == 3'd0) begin
                  s = after_fields(s);
               end
            end
            xsrc_pkg::PH_CALL: begin
               outb         = s.call_value[7:0];
               s.call_value = {8'h00, s.call_value[31:8]};
               if (s.bytes_left != 3'd0) begin
                  s.bytes_left = s.bytes_left - 3'd1;
               end
               if (s.bytes_left == 3'd0) begin
                  s.call_value = 32'd0;
                  s.phase      = xsrc_pkg::PH_START;
               end
            end
            xsrc_pkg::PH_IMM: begin
               s.flag_imm = 1'b0;
               s.flag_rip = 1'b0;
               s.phase    = xsrc_pkg::PH_START;
            end
            default: s = clear_parse(s);
         endcase

         if (take_op) begin
            s.flag_imm = 1'b0;
            s.flag_rip = 1'b0;
            unique case (opc)
               xsrc_pkg::OP_ESC:    s.phase = xsrc_pkg::PH_OPC2;
               xsrc_pkg::OP_SINGLE: s.phase = xsrc_pkg::PH_START;
               xsrc_pkg::OP_IMM: begin
                  s.flag_imm = 1'b1;
                  s.phase    = xsrc_pkg::PH_IMM;
               end
               xsrc_pkg::OP_MODRM:  s.phase = xsrc_pkg::PH_MODRM;
               xsrc_pkg::OP_IRET: begin
                  s          = clear_parse(s);
                  s.finished = 1'b1;
                  status     = xsrc_pkg::ST_IRET;
               end
               xsrc_pkg::OP_CALL: begin
                  // Target offset is taken relative to the first rel32 byte.
                  s.call_value = cfg.call_offset_base - (32'(s.pos) + 32'd1);
                  s.bytes_left = 3'd4;
                  s.phase      = xsrc_pkg::PH_CALL;
               end
               default: begin
                  s          = clear_parse(s);
                  s.finished = 1'b1;
                  status     = xsrc_pkg::ST_ERROR;
               end
            endcase
         end
      end

      if (!no_copy) begin
         s.pos = s.pos + xsrc_pkg::PositionBits'(1);
      end else begin
         outb = 8'h00;
      end
   end

   assign nxt_state            = s;
   assign result.copied_byte   = outb;
   assign result.byte_position = xsrc_pkg::OutPosBits'(pos_cur);
   assign result.status        = status;

endmodule

// ----- sv/x86_subset_relocating_copier.sv -----
// Top level of the relocating x86-64 code copier: channels, registers and checks.
//
// The copier takes one code byte per beat and returns exactly one result beat per
// code byte: the byte as written to the destination, its offset in the region and
// a status. It follows a small x86-64 subset (REX, the supported opcodes, 0F BA,
// ModRM, SIB, displacements, imm8 and call rel32), adds the relocation distance to
// RIP-relative disp32 fields and rewrites call targets toward the callback. It
// sustains one byte per clock while results are taken: a byte is captured in an
// input register, decoded in one pass of combinational logic against the parse
// state, and enters the result register when that register is free or draining. The input side
// stays ready whenever the result register is empty or is being drained in the same
// cycle.
// After reset the block ignores bytes until a beat with region_start set opens a
// region. Registers are written through the csr channel, which is always ready,
// and should only be written while no beat is in flight.
`include "x86_subset_relocating_copier_defines.svh"

module x86_subset_relocating_copier (
   input  logic        clock,
   input  logic        reset,
   xsrc_req_if.sink    req_chan,
   xsrc_rsp_if.source  rsp_chan,
   xsrc_csr_if.sink    csr_chan
);

   // Input register stage.
   logic       s1_vld_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;

   // Result register stage.
   logic                 out_vld_ff;
   xsrc_pkg::result_type out_res_ff;
   xsrc_pkg::result_type out_res_in;

   // Parse state and configuration registers.
   xsrc_pkg::parse_state_type st_ff;
   xsrc_pkg::parse_state_type st_in;
   xsrc_pkg::csr_type         cfg_ff;

   logic req_take;
   logic adv;

   // Terms used by the checks below.
   logic phase_at_start;
   logic dropped_beat;

   // The decoded byte moves on whenever the result register is free or draining.
   assign adv      = s1_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_vld_ff || adv;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.copied_byte   = out_res_ff.copied_byte;
   assign rsp_chan.byte_position = out_res_ff.byte_position;
   assign rsp_chan.status        = out_res_ff.status;

   xsrc_step u_step (
      .cur_state    (st_ff),
      .cfg          (cfg_ff),
      .code_byte    (s1_byte_ff),
      .region_start (s1_start_ff),
      .nxt_state    (st_in),
      .result       (out_res_in)
   );

   // Control state, parse state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff                  <= 1'b0;
         out_vld_ff                 <= 1'b0;
         st_ff                      <= xsrc_pkg::ParseReset;
         cfg_ff.reloc_distance      <= 32'd0;
         cfg_ff.call_offset_base    <= 32'd0;
         cfg_ff.length_limit        <= 16'd1024;
      end else begin
         s1_vld_ff <= req_take || (s1_vld_ff && !adv);
         if (adv) begin
            out_vld_ff <= 1'b1;
            st_ff      <= st_in;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (xsrc_pkg::reg_index_type'(csr_chan.reg_index))
               xsrc_pkg::REG_RELOC:     cfg_ff.reloc_distance   <= csr_chan.wr_data;
               xsrc_pkg::REG_CALL_BASE: cfg_ff.call_offset_base <= csr_chan.wr_data;
               xsrc_pkg::REG_LIMIT:     cfg_ff.length_limit     <= csr_chan.wr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_chan.code_byte;
         s1_start_ff <= req_chan.region_start;
      end
      if (adv) begin
         out_res_ff <= out_res_in;
      end
   end

   assign phase_at_start = (st_ff.phase == xsrc_pkg::PH_START);
   assign dropped_beat   = out_vld_ff && (out_res_ff.status == xsrc_pkg::ST_IGNORE ||
                                          out_res_ff.status == xsrc_pkg::ST_LIMIT);

   // Reset leaves the block idle, empty and waiting for a region start.
   `XSRC_ASSERT_NR(a_reset_idle, clock, reset |=> (st_ff.finished && !out_vld_ff && !s1_vld_ff))
   // A finished region always has its parse state cleared back to instruction start.
   `XSRC_ASSERT(a_fin_parse_clear, clock, reset, st_ff.finished |-> phase_at_start)
   // Beats that are dropped after the end or at the limit never carry a byte.
   `XSRC_ASSERT(a_dropped_zero, clock, reset, dropped_beat |-> (out_res_ff.copied_byte == 8'h00))
   // A captured byte that cannot move on stays in the input register.
   `XSRC_ASSERT(a_stage_hold, clock, reset, (s1_vld_ff && !adv) |=> s1_vld_ff)

endmodule
